FILE: rtl/tqws_pkg.sv
// Package for the two-queue weighted scheduler: widths, reset values, codes
// and the controller/datapath interface structs.
// Depends on nothing; every other file but tqws_ram refers to it by scoped names.
`timescale 1ns / 1ps

package tqws_pkg;

   // Sizes and field widths.
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int WEIGHT_W            = 4;
   localparam int ID_W                = 16;
   localparam int AMOUNT_W            = 24;
   localparam int ENTRY_W             = ID_W + AMOUNT_W;
   localparam int TOTAL_W             = 32;

   // Reset values.
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 4'd2;
   localparam logic [ID_W-1:0]     NEXT_ID_RESET = 16'd1;

   // Request command codes.
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_SERVE = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_PUSHED = 2'd0;
   localparam logic [1:0] STATUS_FULL   = 2'd1;
   localparam logic [1:0] STATUS_SERVED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_en;    // accepted push request
      logic pop_en;     // accepted serve request with an entry waiting
      logic empty_en;   // accepted serve request with nothing waiting
      logic finish_en;  // store read data is valid, complete the serve
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_source; // at least one queue holds an entry
   } dp_status_type;

endpackage

FILE: rtl/two_queue_weighted_scheduler.sv
// Two-queue weighted round-robin scheduler, top level.
// Push or empty serve: result strobe in the cycle after the request; a push is
// accepted every cycle while busy is low. Serve with an entry: registered store
// read, then the read state registers the result; busy is high for one cycle.
// Synchronous reset empties both queues, restores the weight to 2 and the id to 1.
// The receiver cannot stall; each result is presented for exactly one cycle.
`timescale 1ns / 1ps

module two_queue_weighted_scheduler #(
   parameter int QUEUE_DEPTH = tqws_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic                          req_high_priority,
   input  logic [tqws_pkg::AMOUNT_W-1:0] req_amount_cents,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [tqws_pkg::ID_W-1:0]     rsp_entry_id,
   output logic [tqws_pkg::AMOUNT_W-1:0] rsp_served_amount,
   output logic                          rsp_served_from_high,
   output logic [tqws_pkg::TOTAL_W-1:0]  rsp_delivered_total,
   output logic [tqws_pkg::TOTAL_W-1:0]  rsp_amount_sum,
   input  logic                          csr_write_enable,
   input  logic [tqws_pkg::WEIGHT_W-1:0] csr_write_data
);

   tqws_pkg::ctrl_cmd_type  ctrl_cmd;
   tqws_pkg::dp_status_type dp_status;

   // Controller.
   tqws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_cmd    (req_cmd),
      .dp_status  (dp_status),
      .busy       (busy),
      .ctrl_cmd   (ctrl_cmd),
      .rsp_strobe (rsp_strobe)
   );

   // Datapath.
   tqws_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .ctrl_cmd             (ctrl_cmd),
      .dp_status            (dp_status),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_high_priority    (req_high_priority),
      .req_amount_cents     (req_amount_cents),
      .rsp_status           (rsp_status),
      .rsp_entry_id         (rsp_entry_id),
      .rsp_served_amount    (rsp_served_amount),
      .rsp_served_from_high (rsp_served_from_high),
      .rsp_delivered_total  (rsp_delivered_total),
      .rsp_amount_sum       (rsp_amount_sum)
   );

endmodule

FILE: rtl/tqws_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for both entry stores of the scheduler; depends on nothing.
`timescale 1ns / 1ps

module tqws_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/tqws_ctrl.sv
// Controller state machine of the scheduler: accepts requests, sequences the
// store read of a serve and raises the result strobe. Uses tqws_pkg.
`timescale 1ns / 1ps

module tqws_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_cmd,
   input  tqws_pkg::dp_status_type dp_status,
   output logic                   busy,
   output tqws_pkg::ctrl_cmd_type ctrl_cmd,
   output logic                   rsp_strobe
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_READ = 1'b1;

   logic state_ff, state_in;
   logic strobe_ff, strobe_in;
   logic accept;

   // Command decode for the request accepted in this cycle.
   always_comb begin
      accept             = start && (state_ff == S_IDLE);
      ctrl_cmd.push_en   = accept && (req_cmd == tqws_pkg::CMD_PUSH);
      ctrl_cmd.pop_en    = accept && (req_cmd == tqws_pkg::CMD_SERVE) && dp_status.has_source;
      ctrl_cmd.empty_en  = accept && (req_cmd == tqws_pkg::CMD_SERVE) && !dp_status.has_source;
      ctrl_cmd.finish_en = (state_ff == S_READ);
   end

   // Next state: a serve with an entry passes through the read state for the store read.
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            state_in = ctrl_cmd.pop_en ? S_READ : S_IDLE;
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      strobe_in = ctrl_cmd.push_en || ctrl_cmd.empty_en || ctrl_cmd.finish_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == S_READ);
   assign rsp_strobe = strobe_ff;

endmodule

FILE: rtl/tqws_datapath.sv
// Datapath of the scheduler: queue pointers, the two entry stores, the
// weighted selection, the id counter, saturating totals and result registers.
// Uses tqws_pkg and tqws_ram.
`timescale 1ns / 1ps

module tqws_datapath #(
   parameter int QUEUE_DEPTH = tqws_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tqws_pkg::ctrl_cmd_type           ctrl_cmd,
   output tqws_pkg::dp_status_type          dp_status,
   input  logic                             csr_write_enable,
   input  logic [tqws_pkg::WEIGHT_W-1:0]    csr_write_data,
   input  logic                             req_high_priority,
   input  logic [tqws_pkg::AMOUNT_W-1:0]    req_amount_cents,
   output logic [1:0]                       rsp_status,
   output logic [tqws_pkg::ID_W-1:0]        rsp_entry_id,
   output logic [tqws_pkg::AMOUNT_W-1:0]    rsp_served_amount,
   output logic                             rsp_served_from_high,
   output logic [tqws_pkg::TOTAL_W-1:0]     rsp_delivered_total,
   output logic [tqws_pkg::TOTAL_W-1:0]     rsp_amount_sum
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(QUEUE_DEPTH);
   localparam logic [FILL_W:0]   DEPTH_WIDE = (FILL_W + 1)'(QUEUE_DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [tqws_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

   // Control registers.
   logic [tqws_pkg::WEIGHT_W-1:0] weight_ff, weight_in;
   logic [ADDR_W-1:0]             high_head_ff, high_head_in;
   logic [ADDR_W-1:0]             normal_head_ff, normal_head_in;
   logic [FILL_W-1:0]             high_fill_ff, high_fill_in;
   logic [FILL_W-1:0]             normal_fill_ff, normal_fill_in;
   logic [tqws_pkg::WEIGHT_W-1:0] burst_ff, burst_in;
   logic [tqws_pkg::ID_W-1:0]     next_id_ff, next_id_in;
   logic [tqws_pkg::TOTAL_W-1:0]  served_count_ff, served_count_in;
   logic [tqws_pkg::TOTAL_W-1:0]  sum_ff, sum_in;

   // Payload registers.
   logic                          sel_high_ff, sel_high_in;
   logic [1:0]                    status_ff, status_in;
   logic [tqws_pkg::ID_W-1:0]     id_ff, id_in;
   logic [tqws_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   logic                          from_high_ff, from_high_in;

   logic                          high_avail, normal_avail, prefer_high, take_high;
   logic                          push_full, push_ok;
   logic [FILL_W:0]               high_tail_sum, normal_tail_sum;
   logic [ADDR_W-1:0]             high_tail, normal_tail;
   logic [tqws_pkg::ENTRY_W-1:0]  push_word;
   logic [tqws_pkg::ENTRY_W-1:0]  high_rd_data, normal_rd_data, served_word;
   logic [tqws_pkg::AMOUNT_W-1:0] served_amount;
   logic [tqws_pkg::TOTAL_W:0]    sum_wide;

   // Weighted round robin selection with fallback to the other queue.
   always_comb begin
      high_avail   = (high_fill_ff != '0);
      normal_avail = (normal_fill_ff != '0);
      prefer_high  = (burst_ff < weight_ff);
      take_high    = prefer_high ? high_avail : !normal_avail;
      dp_status.has_source = high_avail || normal_avail;
   end

   // Tail addresses: head plus fill, wrapped once at the queue depth.
   always_comb begin
      high_tail_sum   = {1'b0, FILL_W'(high_head_ff)} + {1'b0, high_fill_ff};
      normal_tail_sum = {1'b0, FILL_W'(normal_head_ff)} + {1'b0, normal_fill_ff};
      if (high_tail_sum >= DEPTH_WIDE) begin
         high_tail_sum = high_tail_sum - DEPTH_WIDE;
      end
      if (normal_tail_sum >= DEPTH_WIDE) begin
         normal_tail_sum = normal_tail_sum - DEPTH_WIDE;
      end
      high_tail   = high_tail_sum[ADDR_W-1:0];
      normal_tail = normal_tail_sum[ADDR_W-1:0];
      push_full   = req_high_priority ? (high_fill_ff == FILL_FULL)
                                      : (normal_fill_ff == FILL_FULL);
      push_ok     = ctrl_cmd.push_en && !push_full;
      push_word   = {next_id_ff, req_amount_cents};
   end

   // Entry stores.
   tqws_ram #(
      .WIDTH (tqws_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_high_store (
      .clock   (clock),
      .wr_en   (push_ok && req_high_priority),
      .wr_addr (high_tail),
      .wr_data (push_word),
      .rd_en   (ctrl_cmd.pop_en && take_high),
      .rd_addr (high_head_ff),
      .rd_data (high_rd_data)
   );

   tqws_ram #(
      .WIDTH (tqws_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_normal_store (
      .clock   (clock),
      .wr_en   (push_ok && !req_high_priority),
      .wr_addr (normal_tail),
      .wr_data (push_word),
      .rd_en   (ctrl_cmd.pop_en && !take_high),
      .rd_addr (normal_head_ff),
      .rd_data (normal_rd_data)
   );

   // Next values of the queue pointers, counters and result registers.
   always_comb begin
      weight_in       = csr_write_enable ? csr_write_data : weight_ff;
      high_head_in    = high_head_ff;
      normal_head_in  = normal_head_ff;
      high_fill_in    = high_fill_ff;
      normal_fill_in  = normal_fill_ff;
      burst_in        = burst_ff;
      next_id_in      = next_id_ff;
      served_count_in = served_count_ff;
      sum_in          = sum_ff;
      sel_high_in     = sel_high_ff;
      status_in       = status_ff;
      id_in           = id_ff;
      amount_in       = amount_ff;
      from_high_in    = from_high_ff;

      served_word   = sel_high_ff ? high_rd_data : normal_rd_data;
      served_amount = served_word[tqws_pkg::AMOUNT_W-1:0];
      sum_wide      = {1'b0, sum_ff} + (tqws_pkg::TOTAL_W + 1)'(served_amount);

      // Push: append to the chosen queue or report it full.
      if (ctrl_cmd.push_en) begin
         amount_in    = '0;
         from_high_in = 1'b0;
         if (push_ok) begin
            status_in  = tqws_pkg::STATUS_PUSHED;
            id_in      = next_id_ff;
            next_id_in = next_id_ff + 1'b1;
            if (req_high_priority) begin
               high_fill_in = high_fill_ff + 1'b1;
            end else begin
               normal_fill_in = normal_fill_ff + 1'b1;
            end
         end else begin
            status_in = tqws_pkg::STATUS_FULL;
            id_in     = '0;
         end
      end

      // Serve with nothing waiting.
      if (ctrl_cmd.empty_en) begin
         status_in    = tqws_pkg::STATUS_EMPTY;
         id_in        = '0;
         amount_in    = '0;
         from_high_in = 1'b0;
      end

      // Serve: pop the selected queue and move the burst count.
      if (ctrl_cmd.pop_en) begin
         sel_high_in = take_high;
         if (take_high) begin
            high_head_in = (high_head_ff == LAST_ADDR) ? '0 : high_head_ff + 1'b1;
            high_fill_in = high_fill_ff - 1'b1;
            if (prefer_high) begin
               burst_in = burst_ff + 1'b1;
            end
         end else begin
            normal_head_in = (normal_head_ff == LAST_ADDR) ? '0 : normal_head_ff + 1'b1;
            normal_fill_in = normal_fill_ff - 1'b1;
            if (!prefer_high) begin
               burst_in = '0;
            end
         end
      end

      // Serve completion: read data is in, update the saturating totals.
      if (ctrl_cmd.finish_en) begin
         status_in    = tqws_pkg::STATUS_SERVED;
         id_in        = served_word[tqws_pkg::ENTRY_W-1:tqws_pkg::AMOUNT_W];
         amount_in    = served_amount;
         from_high_in = sel_high_ff;
         if (served_count_ff != TOTAL_MAX) begin
            served_count_in = served_count_ff + 1'b1;
         end
         sum_in = sum_wide[tqws_pkg::TOTAL_W] ? TOTAL_MAX : sum_wide[tqws_pkg::TOTAL_W-1:0];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff       <= tqws_pkg::WEIGHT_RESET;
         high_head_ff    <= '0;
         normal_head_ff  <= '0;
         high_fill_ff    <= '0;
         normal_fill_ff  <= '0;
         burst_ff        <= '0;
         next_id_ff      <= tqws_pkg::NEXT_ID_RESET;
         served_count_ff <= '0;
         sum_ff          <= '0;
      end else begin
         weight_ff       <= weight_in;
         high_head_ff    <= high_head_in;
         normal_head_ff  <= normal_head_in;
         high_fill_ff    <= high_fill_in;
         normal_fill_ff  <= normal_fill_in;
         burst_ff        <= burst_in;
         next_id_ff      <= next_id_in;
         served_count_ff <= served_count_in;
         sum_ff          <= sum_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      sel_high_ff  <= sel_high_in;
      status_ff    <= status_in;
      id_ff        <= id_in;
      amount_ff    <= amount_in;
      from_high_ff <= from_high_in;
   end

   assign rsp_status           = status_ff;
   assign rsp_entry_id         = id_ff;
   assign rsp_served_amount    = amount_ff;
   assign rsp_served_from_high = from_high_ff;
   assign rsp_delivered_total  = served_count_ff;
   assign rsp_amount_sum       = sum_ff;

endmodule
